// File: hw/rtl/metc_pkg.sv
// ----------------------------------------------------------------------------
// metc_pkg
// Shared types, constants and codes for the monthly energy trip control.
// ----------------------------------------------------------------------------
`default_nettype none

package metc_pkg;

  localparam int STAGES_DEF = 8;

  localparam int TIME_W     = 32;
  localparam int ENERGY_W   = 48;
  localparam int LIMIT_W    = 47;
  localparam int PCT_W      = 8;
  localparam int GAP_W      = 16;
  localparam int MASK_W     = 8;
  localparam int TURN_W     = 4;
  localparam int COUNT_W    = 16;

  // limit arithmetic
  localparam int PCT_DIV    = 100;
  localparam int PCT_BASE   = 100;
  localparam int ALARM_DEF  = 80;
  localparam int MUL_A_W    = 49;   // trip limit fits in 49 bits
  localparam int MUL_B_W    = 9;    // 100 + float fits in 9 bits
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int TRIP_W     = 49;
  localparam int ALARM_W    = 51;
  localparam int PROD_W     = 64;
  localparam int DIV_BITS   = 8;    // quotient bits per cycle
  localparam int DIV_STEPS  = PROD_W / DIV_BITS;
  localparam int REM_W      = $clog2(PCT_DIV);

  localparam logic [GAP_W-1:0] GAP_RESET = 16'd60;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LIMIT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TURNS_MASK = 3'd0,
    CFG_BASE_LIMIT = 3'd1,
    CFG_FLOAT_PCT  = 3'd2,
    CFG_ALARM_PCT  = 3'd3,
    CFG_TRIP_GAP   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                       enabled;
    logic [TIME_W-1:0]          now_seconds;
    logic                       month_changed;
    logic signed [ENERGY_W-1:0] month_energy;
    logic                       guarantee;
  } in_t;

  typedef struct packed {
    logic [MASK_W-1:0]  tripped_turns;
    logic               alarm_on;
    logic               over_limit;
    logic [TURN_W-1:0]  next_turn;
    logic [COUNT_W-1:0] trip_count;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV1_GO,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2_GO,
    ST_DIV2,
    ST_DECIDE,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic mul_second;
    logic div_start;
    logic save_trip;
    logic decide;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic skip_math;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/metc_div.sv
// ----------------------------------------------------------------------------
// metc_div
// Divide by 100, eight quotient bits per cycle with a narrow remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module metc_div
  import metc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  output logic                   done,
  output logic [PROD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [REM_W:0]   DIVISOR  = (REM_W + 1)'(PCT_DIV);

  logic [PROD_W-1:0] q, q_next;
  logic [REM_W-1:0]  rem, rem_next;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [REM_W:0]    part;

  always_comb begin
    q_next   = q;
    rem_next = rem;
    part     = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      part   = {rem_next, q_next[PROD_W-1]};
      q_next = {q_next[PROD_W-2:0], 1'b0};
      if (part >= DIVISOR) begin
        rem_next  = REM_W'(part - DIVISOR);
        q_next[0] = 1'b1;
      end else begin
        rem_next = part[REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (busy) begin
      q   <= q_next;
      rem <= rem_next;
    end
  end

  assign done     = busy && (cnt == CNT_LAST);
  assign quotient = q;

endmodule

`default_nettype wire

// File: hw/rtl/metc_ctrl.sv
// ----------------------------------------------------------------------------
// metc_ctrl
// Sequencer: input capture, two multiply/divide passes unless skipped, decision, output.
// ----------------------------------------------------------------------------
`default_nettype none

module metc_ctrl
  import metc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_PREP;
      end
      ST_PREP: begin
        // disabled, month change or no limit: nothing to compute
        state_next = status.skip_math ? ST_DECIDE : ST_DIV1_GO;
      end
      ST_DIV1_GO: state_next = ST_DIV1;
      ST_DIV1: begin
        if (status.div_done) state_next = ST_MUL2;
      end
      ST_MUL2:    state_next = ST_DIV2_GO;
      ST_DIV2_GO: state_next = ST_DIV2;
      ST_DIV2: begin
        if (status.div_done) state_next = ST_DECIDE;
      end
      ST_DECIDE:  state_next = ST_WRITE;
      ST_WRITE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_PREP: begin
        cmd.mul_en = 1'b1;
      end
      ST_DIV1_GO, ST_DIV2_GO: begin
        cmd.div_start = 1'b1;
      end
      ST_MUL2: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_second = 1'b1;
        cmd.save_trip  = 1'b1;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
      end
      ST_WRITE: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/metc_dp.sv
// ----------------------------------------------------------------------------
// metc_dp
// Datapath: configuration registers, limit arithmetic, trip state and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module metc_dp
  import metc_pkg::*;
#(
  parameter int STAGES = STAGES_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire in_t                   in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output out_t                       out_data,
  input  wire cmd_t                  cmd,
  output status_t                    status
);

  localparam int IDX_W = (STAGES > 1) ? $clog2(STAGES) : 1;

  // configuration
  logic [MASK_W-1:0]  turns_mask;
  logic [LIMIT_W-1:0] base_limit;
  logic [PCT_W-1:0]   float_pct;
  logic [PCT_W-1:0]   alarm_pct;
  logic [GAP_W-1:0]   trip_gap;

  // control state
  logic [STAGES-1:0]  turn_state, turn_state_next;
  logic [TIME_W-1:0]  last_trip, last_trip_next;
  logic               alarm_flag, alarm_flag_next;
  logic               over_flag, over_flag_next;
  logic [COUNT_W-1:0] trips_done, trips_done_next;
  logic [TURN_W-1:0]  free_stage, free_stage_next;

  in_t                item;
  logic [PROD_W-1:0]  prod;
  logic [TRIP_W-1:0]  trip_limit;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [PCT_W-1:0]   factor;

  logic               div_done;
  logic [PROD_W-1:0]  quotient;
  logic [ALARM_W-1:0] alarm_limit;

  logic [STAGES-1:0]  ctrl, masked, avail, onehot;
  logic [IDX_W-1:0]   idx;
  logic               has_free;
  logic [TURN_W-1:0]  free_code;
  logic               e_neg;
  logic [ENERGY_W-2:0] e_mag;
  logic               below_alarm, below_trip;
  logic [TIME_W-1:0]  last_eff;
  logic               wait_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      turns_mask <= '0;
      base_limit <= '0;
      float_pct  <= '0;
      alarm_pct  <= '0;
      trip_gap   <= GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TURNS_MASK: turns_mask <= cfg_data[MASK_W-1:0];
        CFG_BASE_LIMIT: base_limit <= cfg_data[LIMIT_W-1:0];
        CFG_FLOAT_PCT:  float_pct  <= cfg_data[PCT_W-1:0];
        CFG_ALARM_PCT:  alarm_pct  <= cfg_data[PCT_W-1:0];
        CFG_TRIP_GAP:   trip_gap   <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item <= in_data;
    end
  end

  // shared multiplier: base * (100 + float), then trip limit * factor
  assign factor = (alarm_pct == '0) ? PCT_W'(ALARM_DEF) : alarm_pct;
  assign mul_a  = cmd.mul_second ? quotient[TRIP_W-1:0]
                                 : MUL_A_W'(base_limit);
  assign mul_b  = cmd.mul_second ? MUL_B_W'(factor)
                                 : MUL_B_W'(PCT_BASE) + MUL_B_W'(float_pct);
  assign mul_p  = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PROD_W'(mul_p);
    end
    if (cmd.save_trip) begin
      trip_limit <= quotient[TRIP_W-1:0];
    end
  end

  metc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .done     (div_done),
    .quotient (quotient)
  );

  assign alarm_limit = quotient[ALARM_W-1:0];

  // stage selection
  assign ctrl   = turns_mask[STAGES-1:0];
  assign masked = turn_state & ctrl;
  assign avail  = ctrl & ~masked;

  always_comb begin
    has_free = 1'b0;
    idx      = '0;
    for (int k = STAGES - 1; k >= 0; k--) begin
      if (avail[k]) begin
        has_free = 1'b1;
        idx      = IDX_W'(k);
      end
    end
  end

  assign free_code = has_free ? TURN_W'(idx) + TURN_W'(1) : '0;
  assign onehot    = STAGES'(1) << idx;

  // limit compare; negative energy is unreadable and counts as low
  assign e_neg       = item.month_energy[ENERGY_W-1];
  assign e_mag       = item.month_energy[ENERGY_W-2:0];
  assign below_alarm = e_neg || (ALARM_W'(e_mag) < alarm_limit);
  assign below_trip  = e_neg || (TRIP_W'(e_mag) < trip_limit);

  // a clock that stepped back drops the spacing reference
  assign last_eff = (last_trip > item.now_seconds) ? '0 : last_trip;
  assign wait_gap = (last_eff != '0) &&
                    ({1'b0, item.now_seconds} <
                     ({1'b0, last_eff} + (TIME_W + 1)'(trip_gap)));

  always_comb begin
    turn_state_next = turn_state;
    last_trip_next  = last_trip;
    alarm_flag_next = alarm_flag;
    over_flag_next  = over_flag;
    trips_done_next = trips_done;
    free_stage_next = free_stage;
    if (!item.enabled || item.month_changed) begin
      turn_state_next = '0;
      last_trip_next  = '0;
      alarm_flag_next = 1'b0;
      over_flag_next  = 1'b0;
    end else begin
      turn_state_next = masked;
      free_stage_next = free_code;
      if (base_limit != '0) begin
        priority if (below_alarm) begin
          turn_state_next = '0;
          last_trip_next  = '0;
          alarm_flag_next = 1'b0;
          over_flag_next  = 1'b0;
        end else if (below_trip) begin
          turn_state_next = '0;
          last_trip_next  = '0;
          over_flag_next  = 1'b0;
          alarm_flag_next = has_free;
        end else if (item.guarantee) begin
          turn_state_next = '0;
          last_trip_next  = '0;
          alarm_flag_next = 1'b0;
          over_flag_next  = 1'b1;
        end else begin
          over_flag_next = 1'b1;
          if (!has_free) begin
            alarm_flag_next = 1'b0;
          end else begin
            alarm_flag_next = 1'b1;
            last_trip_next  = last_eff;
            if (!wait_gap) begin
              last_trip_next  = item.now_seconds;
              turn_state_next = masked | onehot;
              trips_done_next = trips_done + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_state <= '0;
      last_trip  <= '0;
      alarm_flag <= 1'b0;
      over_flag  <= 1'b0;
      trips_done <= '0;
      free_stage <= '0;
    end else if (cmd.decide) begin
      turn_state <= turn_state_next;
      last_trip  <= last_trip_next;
      alarm_flag <= alarm_flag_next;
      over_flag  <= over_flag_next;
      trips_done <= trips_done_next;
      free_stage <= free_stage_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.tripped_turns <= MASK_W'(turn_state);
      out_data.alarm_on      <= alarm_flag;
      out_data.over_limit    <= over_flag;
      out_data.next_turn     <= free_stage;
      out_data.trip_count    <= trips_done;
    end
  end

  assign status.skip_math = !item.enabled || item.month_changed || (base_limit == '0);
  assign status.div_done  = div_done;
  assign status.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

// File: hw/rtl/monthly_energy_trip_control.sv
// ----------------------------------------------------------------------------
// monthly_energy_trip_control
// Monthly energy limit with alarm zone and staged relay tripping.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one evaluation tick per transaction (enable, time, month change,
//           month energy, guarantee flag).
//   out_* : one status result per tick (tripped stages, alarm, over limit,
//           next free stage, trip count).
//   cfg_* : register writes by index, always ready; write only while idle.
// Path from input transaction to out_valid: input capture, then two
//   multiply and divide-by-100 passes at 8 quotient bits per cycle, then the
//   decision; the passes are skipped when the block is disabled, the month
//   changed or the base limit is zero. Ticks are handled one at a time; the
//   next tick is taken in the cycle after the result is loaded.
// A result held by a stalled receiver does not block the next tick; only the
//   load of the following result waits for the output register to free up.
// Reset (rst, synchronous) clears the configuration to its defaults, the trip
//   state, the trip count and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module monthly_energy_trip_control
  import metc_pkg::*;
#(
  parameter int STAGES = STAGES_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  metc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  metc_dp #(
    .STAGES (STAGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

// File: hw/rtl/metc_chk.sv
// ----------------------------------------------------------------------------
// metc_chk
// Port-level checks for the monthly energy trip control, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module metc_chk
  import metc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one tick in flight: no back-to-back transactions
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a tick is in flight");

  // next stage code never beyond the stage count
  a_next_turn_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.next_turn <= TURN_W'(STAGES_DEF))
    else $error("next_turn out of range");

endmodule

bind monthly_energy_trip_control metc_chk u_metc_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
